// File: rtl/bb3_pkg.sv
package bb3_pkg;

    localparam int CH_W            = 8;
    localparam int PIX_W           = 3 * CH_W;
    localparam int CFG_W           = 11;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int RESET_WIDTH     = 640;
    localparam int RESET_HEIGHT    = 480;
    localparam int QUEUE_DEPTH     = 4;

    // mean datapath: per-channel sum of up to nine pixels, then floor((2*sum+count)/(2*count))
    // as a multiply by a rounded-up reciprocal of 2*count
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int N_W         = 13;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = N_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic due;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } flags_t;

    // one window column: row above, middle row, newest row
    typedef struct packed {
        pix_t up;
        pix_t mid;
        pix_t pix;
    } column_t;

    typedef struct packed {
        column_t col;
        flags_t  flags;
    } entry_t;

    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bb3_in_if.sv
interface bb3_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [bb3_pkg::CH_W-1:0]  in_red;
    logic [bb3_pkg::CH_W-1:0]  in_green;
    logic [bb3_pkg::CH_W-1:0]  in_blue;

    modport source (output valid, command, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, command, in_red, in_green, in_blue, output ready);
endinterface

// File: rtl/bb3_out_if.sv
interface bb3_out_if;
    logic                      valid;
    logic                      ready;
    logic [bb3_pkg::CH_W-1:0]  out_red;
    logic [bb3_pkg::CH_W-1:0]  out_green;
    logic [bb3_pkg::CH_W-1:0]  out_blue;
    logic                      frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// File: rtl/box_blur_3x3_edge_aware_top.sv
// Path: a pixel word that completes an output yields it after the line store read,
//   queue, window, sums, reciprocal multiply and output register.
// Throughput: one word per cycle while the queue has room, set by the single read port
//   of the line store, which every pixel word uses once; drain and ignored words go at that rate too.
// Reset: position counters clear, frame size returns to 640 x 480; the line store
//   is not cleared and needs no clearing pass, so the block is ready at once.
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
    bb3_in_if.sink                        in_ch,
    bb3_out_if.source                     out_ch
);

    localparam int QD  = bb3_pkg::QUEUE_DEPTH;
    localparam int QCW = $clog2(QD + 1);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW  = 2 * bb3_pkg::PIX_W;
    localparam int EW  = $bits(bb3_pkg::entry_t);

    // front to queue
    logic              q_push;
    bb3_pkg::entry_t   q_push_entry;
    // queue to back
    logic              q_pop;
    logic              q_empty;
    logic [QCW-1:0]    q_count;
    logic [EW-1:0]     q_pop_data;
    bb3_pkg::entry_t   q_pop_entry;

    // line store: upper and middle rows share one word per column
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [LW-1:0]     ram_wdata, ram_rdata;

    // Front: take words, classify pixel / drain / ignore, step the position
    // counters and rotate the line store.
    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .QDEPTH     (QD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_entry   (q_push_entry),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bb3_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Short queue so that output stalls do not ripple back to the line store.
    bb3_fifo #(
        .WIDTH (EW),
        .DEPTH (QD)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_entry),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    assign q_pop_entry = q_pop_data;

    // Back: shift the 3x3 window, sum the in-frame neighbors, divide and hold
    // the result word until taken.
    bb3_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_pop_entry),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

    // Front credit check must keep the queue from overflowing.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |-> (q_count < QCW'(QD)))
        else $error("queue push while full");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("queue pop while empty");

    // A held result word must not be overwritten by the back pipeline.
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.out_red)
                                             && $stable(out_ch.frame_end)))
        else $error("result word changed while stalled");

endmodule

// File: rtl/bb3_ram.sv
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bb3_fifo.sv
module bb3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

// File: rtl/bb3_front.sv
module bb3_front #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF,
    parameter int QDEPTH     = bb3_pkg::QUEUE_DEPTH
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]                    cfg_data,
    bb3_in_if.sink                                       in_ch,
    input  logic [$clog2(QDEPTH+1)-1:0]                  q_count,
    output logic                                         q_push,
    output bb3_pkg::entry_t                              q_entry,
    output logic                                         ram_we,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] ram_waddr,
    output logic [2*bb3_pkg::PIX_W-1:0]                  ram_wdata,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] ram_raddr,
    input  logic [2*bb3_pkg::PIX_W-1:0]                  ram_rdata
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ORW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int SW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int QCW = $clog2(QDEPTH + 1);
    localparam int XA  = (SW > HW) ? SW : HW;
    localparam int XW  = ((XA > bb3_pkg::CFG_W) ? XA : bb3_pkg::CFG_W) + 2;
    localparam int PW  = bb3_pkg::PIX_W;
    localparam int RST_W = (bb3_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                              : bb3_pkg::RESET_WIDTH;
    localparam int RST_H = (bb3_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : bb3_pkg::RESET_HEIGHT;

    logic [SW-1:0]  img_w_reg, img_w_next;
    logic [HW-1:0]  img_h_reg, img_h_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [ORW-1:0] out_row_reg, out_row_next;

    logic             s1_valid_reg;
    logic [CW-1:0]    s1_addr_reg;
    bb3_pkg::pix_t    s1_pix_reg;
    bb3_pkg::flags_t  s1_flags_reg;
    logic             s1_fwd_reg;
    logic [2*PW-1:0]  fwd_data_reg;

    logic             accept, pending, push, due, col_wrap;
    bb3_pkg::pix_t    pix_in;
    bb3_pkg::flags_t  flags;
    logic [XW-1:0]    w_raw, h_raw;
    logic [2*PW-1:0]  rd;

    assign in_ch.ready = ((QCW + 1)'(q_count) + (QCW + 1)'(s1_valid_reg))
                         < (QCW + 1)'(QDEPTH);
    assign accept  = in_ch.valid && in_ch.ready;
    assign pending = XW'(in_row_reg) < XW'(img_h_reg);
    assign push    = accept && (!pending || (in_ch.command == bb3_pkg::CMD_PIXEL));
    assign pix_in  = pending ? {in_ch.in_red, in_ch.in_green, in_ch.in_blue} : '0;
    assign due     = (in_row_reg >= RW'(2)) || ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign col_wrap = (XW'(in_col_reg) + XW'(1)) >= XW'(img_w_reg);

    always_comb
    begin
        flags.due    = due;
        flags.top    = (out_row_reg != '0);
        flags.bottom = (XW'(out_row_reg) + XW'(1)) < XW'(img_h_reg);
        flags.left   = (out_col_reg != '0);
        flags.right  = (XW'(out_col_reg) + XW'(1)) < XW'(img_w_reg);
        flags.last   = !flags.bottom && !flags.right;
    end

    // clamp sizes: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        w_raw = XW'(cfg_data);
        h_raw = XW'(cfg_data);
        if (w_raw == '0)
        begin
            w_raw = XW'(1);
        end
        if (w_raw > XW'(MAX_WIDTH))
        begin
            w_raw = XW'(MAX_WIDTH);
        end
        if (h_raw == '0)
        begin
            h_raw = XW'(1);
        end
        if (h_raw > XW'(MAX_HEIGHT))
        begin
            h_raw = XW'(MAX_HEIGHT);
        end
    end

    always_comb
    begin
        img_w_next   = img_w_reg;
        img_h_next   = img_h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            if (cfg_index == bb3_pkg::REG_WIDTH || cfg_index == bb3_pkg::REG_HEIGHT)
            begin
                if (cfg_index == bb3_pkg::REG_WIDTH)
                begin
                    img_w_next = SW'(w_raw);
                end
                else
                begin
                    img_h_next = HW'(h_raw);
                end
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
        else if (push)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (due)
            begin
                if (flags.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (!flags.right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ORW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg    <= SW'(RST_W);
            img_h_reg    <= HW'(RST_H);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            img_w_reg    <= img_w_next;
            img_h_reg    <= img_h_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            s1_valid_reg <= push;
        end
    end

    // line store read-modify-write: the word written now is forwarded to a read
    // of the same column issued in the same cycle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_addr_reg  <= in_col_reg;
            s1_pix_reg   <= pix_in;
            s1_flags_reg <= flags;
            s1_fwd_reg   <= s1_valid_reg && (s1_addr_reg == in_col_reg);
        end
        fwd_data_reg <= ram_wdata;
    end

    assign rd        = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    assign ram_raddr = in_col_reg;
    assign ram_we    = s1_valid_reg;
    assign ram_waddr = s1_addr_reg;
    assign ram_wdata = {rd[PW-1:0], s1_pix_reg};

    assign q_push          = s1_valid_reg;
    assign q_entry.col.up  = rd[2*PW-1:PW];
    assign q_entry.col.mid = rd[PW-1:0];
    assign q_entry.col.pix = s1_pix_reg;
    assign q_entry.flags   = s1_flags_reg;

endmodule

// File: rtl/bb3_back.sv
module bb3_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  bb3_pkg::entry_t q_entry,
    output logic            q_pop,
    bb3_out_if.source       out_ch
);

    localparam int CH  = bb3_pkg::CH_W;
    localparam int SUW = bb3_pkg::SUM_W;
    localparam int CNW = bb3_pkg::CNT_W;
    localparam int NW  = bb3_pkg::N_W;
    localparam int PRW = bb3_pkg::PROD_W;

    logic                en;
    bb3_pkg::column_t    win_reg [3];
    logic                s0_valid_reg;
    bb3_pkg::flags_t     s0_flags_reg;
    logic                s1_valid_reg;
    logic [SUW-1:0]      s1_sum_reg [3];
    logic [CNW-1:0]      s1_count_reg;
    logic                s1_last_reg;
    logic                s2_valid_reg;
    logic [PRW-1:0]      s2_prod_reg [3];
    logic                s2_last_reg;
    logic                out_valid_reg;
    logic [CH-1:0]       out_red_reg, out_green_reg, out_blue_reg;
    logic                out_last_reg;

    logic [SUW-1:0]      sum [3];
    logic [CNW-1:0]      count;
    logic [1:0]          n_cols, n_rows;
    logic [2:0]          col_en, row_en;
    logic [NW-1:0]       n_val [3];
    logic [PRW-1:0]      prod [3];
    bb3_pkg::pix_t       cellv;

    assign en    = !out_valid_reg || out_ch.ready;
    assign q_pop = en && !q_empty;

    // masked window sums, one per channel
    always_comb
    begin
        col_en = {s0_flags_reg.right, 1'b1, s0_flags_reg.left};
        row_en = {s0_flags_reg.bottom, 1'b1, s0_flags_reg.top};
        n_cols = 2'd1 + 2'(s0_flags_reg.left) + 2'(s0_flags_reg.right);
        n_rows = 2'd1 + 2'(s0_flags_reg.top) + 2'(s0_flags_reg.bottom);
        count  = CNW'(n_cols) * CNW'(n_rows);
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
        end
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                unique case (r)
                    0:       cellv = win_reg[c].up;
                    1:       cellv = win_reg[c].mid;
                    default: cellv = win_reg[c].pix;
                endcase
                if (col_en[c] && row_en[r])
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        sum[ch] = sum[ch] + SUW'(cellv[(2 - ch) * CH +: CH]);
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            n_val[ch] = NW'({s1_sum_reg[ch], 1'b0}) + NW'(s1_count_reg);
            prod[ch]  = PRW'(n_val[ch]) * PRW'(bb3_pkg::recip(s1_count_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= q_pop && q_entry.flags.due;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            win_reg[0]   <= win_reg[1];
            win_reg[1]   <= win_reg[2];
            win_reg[2]   <= q_entry.col;
            s0_flags_reg <= q_entry.flags;
        end
        if (en)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s1_sum_reg[ch]  <= sum[ch];
                s2_prod_reg[ch] <= prod[ch];
            end
            s1_count_reg  <= count;
            s1_last_reg   <= s0_flags_reg.last;
            s2_last_reg   <= s1_last_reg;
            out_red_reg   <= s2_prod_reg[0][bb3_pkg::RECIP_SHIFT +: CH];
            out_green_reg <= s2_prod_reg[1][bb3_pkg::RECIP_SHIFT +: CH];
            out_blue_reg  <= s2_prod_reg[2][bb3_pkg::RECIP_SHIFT +: CH];
            out_last_reg  <= s2_last_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_red   = out_red_reg;
    assign out_ch.out_green = out_green_reg;
    assign out_ch.out_blue  = out_blue_reg;
    assign out_ch.frame_end = out_last_reg;

endmodule
